[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition: label");

`endif

[rtl/acht_pkg.sv]
// ----------------------------------------------------------------------------
// acht_pkg
// sizes and types for the associative cache hit tracker
// ----------------------------------------------------------------------------
package acht_pkg;

    localparam int ENTRIES     = 16;
    localparam int ADDR_WIDTH  = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_WIDTH  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // port widths fixed by the item format
    localparam int PORT_ADDR_WIDTH  = 32;
    localparam int PORT_SLOT_WIDTH  = 4;
    localparam int PORT_COUNT_WIDTH = 32;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [ADDR_WIDTH-1:0]  tag_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [SLOT_WIDTH-1:0]  slot_t;

endpackage

[rtl/assoc_cache_hit_tracker.sv]
// ----------------------------------------------------------------------------
// assoc_cache_hit_tracker
// fully associative tag store with saturating hit, miss, read, write counters
// ----------------------------------------------------------------------------
// Each access item (op, address) is looked up against all valid tags at once.
// A match is a hit and leaves the store as it is; a miss writes the address
// into the lowest empty entry, or into entry 0 once every entry is valid.
// One result item comes back per access with hit, slot and the four running
// counts, which stop at their maximum. The block takes one item per clock
// cycle while the result side is not stalled; the item sits in the input
// register, then one compare-and-update step loads the result register
// once the result stage is free.
// Back pressure on m_ready holds the result and stalls the input side only
// when both stages are full. Reset clears the valid bits and the counters;
// tag contents are never read before they are written.
// ----------------------------------------------------------------------------
module assoc_cache_hit_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    // access items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_address,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [3:0]  m_slot,
    output logic [31:0] m_hits_total,
    output logic [31:0] m_misses_total,
    output logic [31:0] m_reads_total,
    output logic [31:0] m_writes_total
);

    localparam int EW = acht_pkg::ENTRIES;
    localparam int AW = acht_pkg::ADDR_WIDTH;
    localparam int CW = acht_pkg::COUNT_WIDTH;
    localparam int SW = acht_pkg::SLOT_WIDTH;
    localparam int PAW = acht_pkg::PORT_ADDR_WIDTH;
    localparam int PSW = acht_pkg::PORT_SLOT_WIDTH;
    localparam int PCW = acht_pkg::PORT_COUNT_WIDTH;

    // input register stage
    logic             in_valid_reg;
    logic             op_reg;
    acht_pkg::tag_t   addr_reg;

    // tag store and its valid bits
    acht_pkg::tag_t   tag_reg [EW];
    logic [EW-1:0]    valid_reg;
    logic [EW-1:0]    valid_next;

    // result register stage
    logic             out_valid_reg;
    logic             hit_reg;
    acht_pkg::slot_t  slot_reg;

    // running counters; they change only when a result is loaded, so they
    // always match the result item on display
    acht_pkg::count_t hit_cnt_reg,   hit_cnt_next;
    acht_pkg::count_t miss_cnt_reg,  miss_cnt_next;
    acht_pkg::count_t read_cnt_reg,  read_cnt_next;
    acht_pkg::count_t write_cnt_reg, write_cnt_next;

    // lookup
    logic [EW-1:0]    match;
    logic             hit_any;
    acht_pkg::slot_t  hit_idx;
    acht_pkg::slot_t  fill_idx;
    acht_pkg::slot_t  slot_next;

    logic             out_free;
    logic             fire;

    logic [AW+PAW-1:0] addr_ext;
    logic [SW+PSW-1:0] slot_ext;
    logic [CW+PCW-1:0] hit_ext, miss_ext, read_ext, write_ext;

    // handshake: the result stage frees up when empty or being taken
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // tag is the full 32-bit address
    assign addr_ext = {{AW{1'b0}}, s_address};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            addr_reg <= addr_ext[AW-1:0];
        end
    end

    // compare against every valid tag, pick lowest match and lowest empty
    always_comb begin
        hit_idx  = '0;
        fill_idx = '0;
        for (int i = 0; i < EW; i++) begin
            match[i] = valid_reg[i] && (tag_reg[i] == addr_reg);
        end
        for (int i = EW - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = SW'(i);
            end
            if (!valid_reg[i]) begin
                fill_idx = SW'(i);
            end
        end
        hit_any   = |match;
        // full store on a miss falls back to entry 0 via the default above
        slot_next = hit_any ? hit_idx : fill_idx;
    end

    // counter updates, saturating at all ones, and valid bit set on a miss
    always_comb begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        read_cnt_next  = read_cnt_reg;
        write_cnt_next = write_cnt_reg;
        valid_next     = valid_reg;
        if (fire) begin
            if (op_reg == acht_pkg::OP_WRITE) begin
                if (write_cnt_reg != '1) write_cnt_next = write_cnt_reg + 1'b1;
            end else begin
                if (read_cnt_reg != '1) read_cnt_next = read_cnt_reg + 1'b1;
            end
            if (hit_any) begin
                if (hit_cnt_reg != '1) hit_cnt_next = hit_cnt_reg + 1'b1;
            end else begin
                if (miss_cnt_reg != '1) miss_cnt_next = miss_cnt_reg + 1'b1;
                valid_next[fill_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            write_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            read_cnt_reg  <= read_cnt_next;
            write_cnt_reg <= write_cnt_next;
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // tag write on a miss, result payload on every processed item
    always_ff @(posedge aclk) begin
        if (fire) begin
            hit_reg  <= hit_any;
            slot_reg <= slot_next;
            if (!hit_any) begin
                tag_reg[fill_idx] <= addr_reg;
            end
        end
    end

    // fit internal widths onto the fixed port widths
    assign slot_ext  = {{PSW{1'b0}}, slot_reg};
    assign hit_ext   = {{PCW{1'b0}}, hit_cnt_reg};
    assign miss_ext  = {{PCW{1'b0}}, miss_cnt_reg};
    assign read_ext  = {{PCW{1'b0}}, read_cnt_reg};
    assign write_ext = {{PCW{1'b0}}, write_cnt_reg};

    assign m_valid        = out_valid_reg;
    assign m_hit          = hit_reg;
    assign m_slot         = slot_ext[PSW-1:0];
    assign m_hits_total   = hit_ext[PCW-1:0];
    assign m_misses_total = miss_ext[PCW-1:0];
    assign m_reads_total  = read_ext[PCW-1:0];
    assign m_writes_total = write_ext[PCW-1:0];

endmodule

[rtl/assoc_cache_hit_tracker_chk.sv]
// ----------------------------------------------------------------------------
// assoc_cache_hit_tracker_chk
// port-level checks for the associative cache hit tracker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module assoc_cache_hit_tracker_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [3:0]  m_slot,
    input logic [31:0] m_hits_total,
    input logic [31:0] m_misses_total,
    input logic [31:0] m_reads_total,
    input logic [31:0] m_writes_total
);

    // stalled result holds
    `ASSERT_CLK(a_result_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_slot) && $stable(m_hits_total))

    // a hit result already counts itself
    `ASSERT_NEVER(a_hit_counted, aclk, aresetn, m_valid && m_hit && (m_hits_total == 32'd0))

    // a miss result already counts itself
    `ASSERT_NEVER(a_miss_counted, aclk, aresetn, m_valid && !m_hit && (m_misses_total == 32'd0))

    // every result counts at least one read or write
    `ASSERT_NEVER(a_op_counted, aclk, aresetn, m_valid && (m_reads_total == 32'd0) && (m_writes_total == 32'd0))

    // hit and miss counts never fall from one result to the next
    `ASSERT_CLK(a_counts_rise, aclk, aresetn, m_valid && m_ready |=> !m_valid || (m_hits_total >= $past(m_hits_total) && m_misses_total >= $past(m_misses_total)))

endmodule

bind assoc_cache_hit_tracker assoc_cache_hit_tracker_chk u_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hit          (m_hit),
    .m_slot         (m_slot),
    .m_hits_total   (m_hits_total),
    .m_misses_total (m_misses_total),
    .m_reads_total  (m_reads_total),
    .m_writes_total (m_writes_total)
);
